### sv/ifr_pkg.sv
// Shared types and constants for the idle-timeout frame receiver.
// No dependencies; imported by ifr_ctrl, ifr_dp and the top level.
`timescale 1ns / 1ps

package ifr_pkg;

  // Frame buffer geometry
  localparam int BUFFER_DEPTH = 16;
  localparam int IDX_W        = $clog2(BUFFER_DEPTH);
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  // Idle counter and limit
  localparam int          TICK_W           = 8;
  localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd10;
  localparam logic [7:0]  IDLE_MAX         = 8'd255;

  // Request kinds
  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_FETCH = 2'd2;

  // Input request payload
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_item_t;

  // Result payload
  typedef struct packed {
    logic       frame_valid;
    logic [7:0] data_byte;
    logic       last;
    logic       overflow;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic store;       // append rx byte, restart idle count
    logic tick;        // advance idle count
    logic load_frame;  // present next frame byte, step read index
    logic load_empty;  // present the no-frame result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic frame_avail; // frame ready with at least one byte
    logic last_byte;   // read index points at the final held byte
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

### sv/idle_timeout_frame_receiver_top.sv
// Top level of the idle-timeout frame receiver: joins controller and
// datapath. Depends on ifr_pkg, ifr_ctrl and ifr_dp.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_data   (in_item_t)
//   out      output     out_valid/out_ready  out_data  (out_item_t)
//   cfg      input      cfg_we               cfg_data  (idle_limit)
//
// Byte and tick requests give no result. A fetch gives one result per
// frame byte (up to 16), handed out one at a time through the single
// frame-buffer read port; a fetch with no ready frame gives one result.
// Reset is synchronous and clears all counters and flags; buffer
// contents need no clearing. A stalled output holds the fetch sequence;
// in_ready is low until the fetch completes.
`timescale 1ns / 1ps

module idle_timeout_frame_receiver_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ifr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ifr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);
  import ifr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  ifr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (in_data.func),
    .status   (status),
    .cmd      (cmd)
  );

  // Buffer, counters and output register
  ifr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .rx_byte   (in_data.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### sv/ifr_dp.sv
// Datapath of the idle-timeout frame receiver: frame buffer, counters,
// idle-limit register and the output register. Depends on ifr_pkg.
`timescale 1ns / 1ps

module ifr_dp (
  input  logic              clk,
  input  logic              rst,
  input  ifr_pkg::cmd_t     cmd,
  output ifr_pkg::status_t  status,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ifr_pkg::out_item_t out_data
);
  import ifr_pkg::*;

  logic [7:0]        mem [BUFFER_DEPTH];
  logic [7:0]        rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  rd_idx_next;
  logic [CNT_W-1:0]  byte_count;
  logic [TICK_W-1:0] idle_ticks;
  logic [TICK_W-1:0] idle_ticks_inc;
  logic [7:0]        idle_limit;
  logic              frame_ready;
  logic              dropped_flag;
  logic              buf_full;

  assign buf_full       = (byte_count == CNT_W'(BUFFER_DEPTH));
  assign idle_ticks_inc = (idle_ticks == IDLE_MAX) ? idle_ticks : idle_ticks + 1'b1;
  assign rd_idx_next    = cmd.load_frame ? rd_idx + 1'b1 : rd_idx;

  // Status back to the controller
  assign status.frame_avail = frame_ready && (byte_count != '0);
  assign status.last_byte   = ((CNT_W'(rd_idx) + 1'b1) == byte_count);
  assign status.out_free    = !out_valid || out_ready;

  // Frame buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store && !buf_full) begin
      mem[byte_count[IDX_W-1:0]] <= rx_byte;
    end
    rd_data <= mem[rd_idx_next];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RESET;
    end else if (cfg_we) begin
      idle_limit <= cfg_data;
    end
  end

  // Frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      idle_ticks   <= '0;
      frame_ready  <= 1'b0;
      dropped_flag <= 1'b0;
      rd_idx       <= '0;
    end else begin
      // Read index rewinds once the final byte is handed out
      if (cmd.load_frame && status.last_byte) begin
        rd_idx <= '0;
      end else begin
        rd_idx <= rd_idx_next;
      end
      if (cmd.store) begin
        idle_ticks <= '0;
        if (buf_full) begin
          dropped_flag <= 1'b1;
        end else begin
          byte_count <= byte_count + 1'b1;
        end
      end
      if (cmd.tick) begin
        idle_ticks <= idle_ticks_inc;
        if ((byte_count != '0) && (idle_ticks_inc >= idle_limit)) begin
          frame_ready <= 1'b1;
        end
      end
      // Final byte handed out: empty the frame
      if (cmd.load_frame && status.last_byte) begin
        byte_count   <= '0;
        frame_ready  <= 1'b0;
        dropped_flag <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_frame || cmd.load_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      out_data.frame_valid <= 1'b1;
      out_data.data_byte   <= rd_data;
      out_data.last        <= status.last_byte;
      out_data.overflow    <= dropped_flag;
    end else if (cmd.load_empty) begin
      out_data.frame_valid <= 1'b0;
      out_data.data_byte   <= 8'd0;
      out_data.last        <= 1'b1;
      out_data.overflow    <= dropped_flag;
    end
  end

endmodule

### sv/ifr_ctrl.sv
// Controller of the idle-timeout frame receiver: accepts requests and
// sequences a fetch one result at a time. Depends on ifr_pkg.
`timescale 1ns / 1ps

module ifr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       func,
  input  ifr_pkg::status_t status,
  output ifr_pkg::cmd_t    cmd
);
  import ifr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (func)
            FUNC_BYTE:  cmd.store = 1'b1;
            FUNC_TICK:  cmd.tick  = 1'b1;
            FUNC_FETCH: state_next = S_FETCH;
            default: ;  // unused code: dropped
          endcase
        end
      end
      S_FETCH: begin
        if (status.out_free) begin
          if (status.frame_avail) begin
            cmd.load_frame = 1'b1;
            if (status.last_byte) begin
              state_next = S_IDLE;
            end
          end else begin
            cmd.load_empty = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
